[src/ctp_pkg.sv]
// Shared types, constants and elaboration-time helpers for the coordinated-turn predictor.
// No dependencies; every other file but ctp_checker imports this package.
package ctp_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int MOD_STEPS    = 17;
  localparam int DIV_STEPS    = 47;
  localparam int CIDX_W       = $clog2(CORDIC_STEPS);
  localparam int MIDX_W       = $clog2(MOD_STEPS);

  localparam logic signed [63:0] PI_Q60      = 64'sh3243F6A8885A308D;
  localparam logic signed [63:0] PI_Q44      = (PI_Q60 + 64'sd32768) >>> 16;
  localparam logic signed [63:0] HALF_PI_Q44 = (PI_Q60 + 64'sd65536) >>> 17;
  localparam logic signed [63:0] TWO_PI_Q44  = (PI_Q60 + 64'sd16384) >>> 15;

  localparam logic signed [47:0] PI_ANG      = 48'(PI_Q44);
  localparam logic signed [47:0] HALF_PI_ANG = 48'(HALF_PI_Q44);
  localparam logic signed [47:0] TWO_PI_ANG  = 48'(TWO_PI_Q44);

  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [33:0] ONE_Q30  = 34'sd1073741824;
  localparam logic [46:0]        Q_LIMIT  = 47'h0_FFFF_FFFF;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic signed [31:0] w;
    logic signed [31:0] lin_x;
    logic signed [31:0] lin_y;
    logic signed [31:0] lin_z;
  } side_t;

  typedef struct packed {
    logic        neg;
    logic [63:0] r;
    side_t       side;
  } mod_t;

  typedef struct packed {
    logic               flip;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [47:0] z;
    side_t              side;
  } cor_t;

  typedef struct packed {
    logic        neg;
    logic [46:0] num;
    logic [31:0] rem;
    logic [46:0] quo;
  } div_lane_t;

  typedef struct packed {
    logic [31:0]        den;
    div_lane_t          so;
    div_lane_t          co;
    logic signed [33:0] s;
    logic signed [33:0] c;
    side_t              side;
  } div_t;

  typedef logic [CORDIC_STEPS-1:0][47:0] atan_tab_t;

  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [47:0] atan_q44(input int i);
    logic signed [63:0] sum;
    logic signed [63:0] term;
    int sh;
    sum = '0;
    if (i == 0) begin
      return 48'(((PI_Q60 >>> 2) + 64'sd32768) >>> 16);
    end
    for (int k = 0; k < 64; k++) begin
      sh = 60 - i * (2 * k + 1);
      if (sh >= 0) begin
        term = $signed(udiv64(64'd1 << sh, 64'(2 * k + 1)));
        if (k[0]) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
    end
    return 48'((sum + 64'sd32768) >>> 16);
  endfunction

  function automatic atan_tab_t build_atan();
    atan_tab_t t;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      t[i] = atan_q44(i);
    end
    return t;
  endfunction

  localparam atan_tab_t ATAN_TAB = build_atan();

  function automatic logic signed [31:0] sat32(input logic signed [69:0] v);
    if (v > 70'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end
    if (v < -70'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

[src/coordinated_turn_predict.sv]
// Coordinated-turn state prediction: one state in, one propagated state out, every cycle unless the output stalls.
// Depends on ctp_pkg, ctp_mod_cell, ctp_cordic_cell and ctp_div_cell.
//
// The block takes one word per clock and returns one word per clock unless the output
// stalls. The chain of cells is made of 17 angle-reduction steps, one CORDIC cell per
// iteration and 47 quotient-bit cells for the division by the turn rate, plus seven
// stages of multiply, fold and saturation. A stall on the output freezes the whole chain;
// in_tready follows out_tready while a result is held. A turn rate of exactly zero gives
// straight-line motion, and every result saturates to the signed 32-bit range.
module coordinated_turn_predict (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, turn_rate, step_time (32 bits each)
  input  logic [255:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z, new_turn_rate
  output logic [223:0] out_tdata
);
  import ctp_pkg::*;

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  logic signed [31:0] in_px, in_py, in_pz, in_vx, in_vy, in_vz, in_w;
  logic signed [32:0] in_dt;
  logic signed [64:0] th_p, pvx_p, pvy_p, pvz_p;

  assign in_px = in_tdata[31:0];
  assign in_py = in_tdata[63:32];
  assign in_pz = in_tdata[95:64];
  assign in_vx = in_tdata[127:96];
  assign in_vy = in_tdata[159:128];
  assign in_vz = in_tdata[191:160];
  assign in_w  = in_tdata[223:192];
  assign in_dt = {1'b0, in_tdata[255:224]};
  assign th_p  = in_w * in_dt;
  assign pvx_p = in_vx * in_dt;
  assign pvy_p = in_vy * in_dt;
  assign pvz_p = in_vz * in_dt;

  logic               a_vld_r;
  logic signed [31:0] a_px_r, a_py_r, a_pz_r, a_vx_r, a_vy_r, a_vz_r, a_w_r;
  logic signed [63:0] a_th_r, a_pvx_r, a_pvy_r, a_pvz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_px_r  <= in_px;
      a_py_r  <= in_py;
      a_pz_r  <= in_pz;
      a_vx_r  <= in_vx;
      a_vy_r  <= in_vy;
      a_vz_r  <= in_vz;
      a_w_r   <= in_w;
      a_th_r  <= th_p[63:0];
      a_pvx_r <= pvx_p[63:0];
      a_pvy_r <= pvy_p[63:0];
      a_pvz_r <= pvz_p[63:0];
    end
  end

  mod_t b_nxt;
  mod_t b_d_r;
  logic b_vld_r;
  mod_t mod_d [MOD_STEPS+1];
  logic mod_v [MOD_STEPS+1];

  always_comb begin
    b_nxt.neg        = a_th_r[63];
    b_nxt.r          = a_th_r[63] ? 64'(-a_th_r) : a_th_r;
    b_nxt.side.px    = a_px_r;
    b_nxt.side.py    = a_py_r;
    b_nxt.side.vx    = a_vx_r;
    b_nxt.side.vy    = a_vy_r;
    b_nxt.side.vz    = a_vz_r;
    b_nxt.side.w     = a_w_r;
    b_nxt.side.lin_x = sat32(70'(a_px_r) + 70'(a_pvx_r >>> 16));
    b_nxt.side.lin_y = sat32(70'(a_py_r) + 70'(a_pvy_r >>> 16));
    b_nxt.side.lin_z = sat32(70'(a_pz_r) + 70'(a_pvz_r >>> 16));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_d_r <= b_nxt;
    end
  end

  assign mod_v[0] = b_vld_r;
  assign mod_d[0] = b_d_r;

  for (genvar j = 0; j < MOD_STEPS; j++) begin : g_mod
    ctp_mod_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .k      (MIDX_W'(MOD_STEPS - 1 - j)),
      .in_vld (mod_v[j]),
      .in_d   (mod_d[j]),
      .out_vld(mod_v[j+1]),
      .out_d  (mod_d[j+1])
    );
  end

  logic signed [47:0] rpos, rs;
  logic               flip;
  cor_t               f_nxt;
  cor_t               f_d_r;
  logic               f_vld_r;
  cor_t               cor_d [CORDIC_STEPS+1];
  logic               cor_v [CORDIC_STEPS+1];

  always_comb begin
    rpos = {1'b0, mod_d[MOD_STEPS].r[46:0]};
    rs   = mod_d[MOD_STEPS].neg ? -rpos : rpos;
    flip = 1'b0;
    if (rs > PI_ANG) begin
      rs = rs - TWO_PI_ANG;
    end else if (rs < -PI_ANG) begin
      rs = rs + TWO_PI_ANG;
    end
    if (rs > HALF_PI_ANG) begin
      rs   = rs - PI_ANG;
      flip = 1'b1;
    end else if (rs < -HALF_PI_ANG) begin
      rs   = rs + PI_ANG;
      flip = 1'b1;
    end
    f_nxt.flip = flip;
    f_nxt.x    = GAIN_Q30;
    f_nxt.y    = '0;
    f_nxt.z    = rs;
    f_nxt.side = mod_d[MOD_STEPS].side;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (en) begin
      f_vld_r <= mod_v[MOD_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_d_r <= f_nxt;
    end
  end

  assign cor_v[0] = f_vld_r;
  assign cor_d[0] = f_d_r;

  for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_cordic
    ctp_cordic_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .idx    (CIDX_W'(j)),
      .in_vld (cor_v[j]),
      .in_d   (cor_d[j]),
      .out_vld(cor_v[j+1]),
      .out_d  (cor_d[j+1])
    );
  end

  logic signed [33:0] pd_s, pd_c;
  logic signed [31:0] pd_w;
  logic signed [48:0] so_num, co_num;
  div_t               p_nxt;
  div_t               p_d_r;
  logic               p_vld_r;
  div_t               div_d [DIV_STEPS+1];
  logic               div_v [DIV_STEPS+1];

  always_comb begin
    pd_s   = cor_d[CORDIC_STEPS].flip ? -cor_d[CORDIC_STEPS].y : cor_d[CORDIC_STEPS].y;
    pd_c   = cor_d[CORDIC_STEPS].flip ? -cor_d[CORDIC_STEPS].x : cor_d[CORDIC_STEPS].x;
    pd_w   = cor_d[CORDIC_STEPS].side.w;
    so_num = 49'(pd_s) <<< 14;
    co_num = (49'(ONE_Q30) - 49'(pd_c)) <<< 14;
    p_nxt.den    = pd_w[31] ? 32'(-pd_w) : pd_w;
    p_nxt.so.neg = so_num[48] ^ pd_w[31];
    p_nxt.so.num = so_num[48] ? 47'(-so_num) : so_num[46:0];
    p_nxt.so.rem = '0;
    p_nxt.so.quo = '0;
    p_nxt.co.neg = co_num[48] ^ pd_w[31];
    p_nxt.co.num = co_num[48] ? 47'(-co_num) : co_num[46:0];
    p_nxt.co.rem = '0;
    p_nxt.co.quo = '0;
    p_nxt.s      = pd_s;
    p_nxt.c      = pd_c;
    p_nxt.side   = cor_d[CORDIC_STEPS].side;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else if (en) begin
      p_vld_r <= cor_v[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_d_r <= p_nxt;
    end
  end

  assign div_v[0] = p_vld_r;
  assign div_d[0] = p_d_r;

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    ctp_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .in_vld (div_v[j]),
      .in_d   (div_d[j]),
      .out_vld(div_v[j+1]),
      .out_d  (div_d[j+1])
    );
  end

  logic [31:0]        so_mag, co_mag;
  logic signed [32:0] so_nxt, co_nxt;
  logic               c1_vld_r;
  logic signed [32:0] c1_so_r, c1_co_r;
  logic signed [33:0] c1_s_r, c1_c_r;
  side_t              c1_side_r;

  always_comb begin
    so_mag = (div_d[DIV_STEPS].so.quo > Q_LIMIT) ? '1 : div_d[DIV_STEPS].so.quo[31:0];
    co_mag = (div_d[DIV_STEPS].co.quo > Q_LIMIT) ? '1 : div_d[DIV_STEPS].co.quo[31:0];
    so_nxt = div_d[DIV_STEPS].so.neg ? -$signed({1'b0, so_mag}) : $signed({1'b0, so_mag});
    co_nxt = div_d[DIV_STEPS].co.neg ? -$signed({1'b0, co_mag}) : $signed({1'b0, co_mag});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_vld_r <= 1'b0;
    end else if (en) begin
      c1_vld_r <= div_v[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_so_r   <= so_nxt;
      c1_co_r   <= co_nxt;
      c1_s_r    <= div_d[DIV_STEPS].s;
      c1_c_r    <= div_d[DIV_STEPS].c;
      c1_side_r <= div_d[DIV_STEPS].side;
    end
  end

  logic signed [64:0] sovx_p, covy_p, covx_p, sovy_p;
  logic signed [65:0] cvx_p, svy_p, svx_p, cvy_p;
  logic               c2_vld_r;
  logic signed [48:0] c2_sovx_r, c2_covy_r, c2_covx_r, c2_sovy_r;
  logic signed [65:0] c2_cvx_r, c2_svy_r, c2_svx_r, c2_cvy_r;
  side_t              c2_side_r;

  assign sovx_p = c1_so_r * c1_side_r.vx;
  assign covy_p = c1_co_r * c1_side_r.vy;
  assign covx_p = c1_co_r * c1_side_r.vx;
  assign sovy_p = c1_so_r * c1_side_r.vy;
  assign cvx_p  = c1_c_r * c1_side_r.vx;
  assign svy_p  = c1_s_r * c1_side_r.vy;
  assign svx_p  = c1_s_r * c1_side_r.vx;
  assign cvy_p  = c1_c_r * c1_side_r.vy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c2_vld_r <= 1'b0;
    end else if (en) begin
      c2_vld_r <= c1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2_sovx_r <= 49'(sovx_p >>> 16);
      c2_covy_r <= 49'(covy_p >>> 16);
      c2_covx_r <= 49'(covx_p >>> 16);
      c2_sovy_r <= 49'(sovy_p >>> 16);
      c2_cvx_r  <= cvx_p;
      c2_svy_r  <= svy_p;
      c2_svx_r  <= svx_p;
      c2_cvy_r  <= cvy_p;
      c2_side_r <= c1_side_r;
    end
  end

  logic signed [66:0]  dvx, dvy;
  logic signed [31:0]  nx, ny, nvx, nvy;
  logic                out_vld_r;
  logic [223:0]        out_d_r;

  always_comb begin
    dvx = 67'(c2_cvx_r) - 67'(c2_svy_r);
    dvy = 67'(c2_svx_r) + 67'(c2_cvy_r);
    if (c2_side_r.w == 0) begin
      nx  = c2_side_r.lin_x;
      ny  = c2_side_r.lin_y;
      nvx = c2_side_r.vx;
      nvy = c2_side_r.vy;
    end else begin
      nx  = sat32(70'(c2_side_r.px) + 70'(c2_sovx_r) - 70'(c2_covy_r));
      ny  = sat32(70'(c2_side_r.py) + 70'(c2_covx_r) + 70'(c2_sovy_r));
      nvx = sat32(70'(dvx >>> 30));
      nvy = sat32(70'(dvy >>> 30));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= c2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_d_r <= {c2_side_r.w, c2_side_r.vz, nvy, nvx, c2_side_r.lin_z, ny, nx};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_d_r;
endmodule

[src/ctp_mod_cell.sv]
// One restoring step of the angle reduction modulo two pi.
// Depends on ctp_pkg.
module ctp_mod_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic [ctp_pkg::MIDX_W-1:0] k,
  input  logic                      in_vld,
  input  ctp_pkg::mod_t             in_d,
  output logic                      out_vld,
  output ctp_pkg::mod_t             out_d
);
  import ctp_pkg::*;

  logic [63:0] step;
  mod_t        d_nxt;
  mod_t        d_r;
  logic        vld_r;

  always_comb begin
    step  = 64'(TWO_PI_Q44) << k;
    d_nxt = in_d;
    if (in_d.r >= step) begin
      d_nxt.r = in_d.r - step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_d   = d_r;
endmodule

[src/ctp_cordic_cell.sv]
// One rotation-mode CORDIC micro-rotation.
// Depends on ctp_pkg (arctangent table).
module ctp_cordic_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic [ctp_pkg::CIDX_W-1:0] idx,
  input  logic                       in_vld,
  input  ctp_pkg::cor_t              in_d,
  output logic                       out_vld,
  output ctp_pkg::cor_t              out_d
);
  import ctp_pkg::*;

  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [47:0] ang;
  cor_t               d_nxt;
  cor_t               d_r;
  logic               vld_r;

  always_comb begin
    xs    = in_d.x >>> idx;
    ys    = in_d.y >>> idx;
    ang   = $signed(ATAN_TAB[idx]);
    d_nxt = in_d;
    if (in_d.z >= 0) begin
      d_nxt.x = in_d.x - ys;
      d_nxt.y = in_d.y + xs;
      d_nxt.z = in_d.z - ang;
    end else begin
      d_nxt.x = in_d.x + ys;
      d_nxt.y = in_d.y - xs;
      d_nxt.z = in_d.z + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_d   = d_r;
endmodule

[src/ctp_div_cell.sv]
// One quotient bit of the two restoring dividers (sin term and one-minus-cos term).
// Depends on ctp_pkg.
module ctp_div_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  ctp_pkg::div_t in_d,
  output logic          out_vld,
  output ctp_pkg::div_t out_d
);
  import ctp_pkg::*;

  logic [32:0] so_sh;
  logic [32:0] co_sh;
  logic        so_ge;
  logic        co_ge;
  div_t        d_nxt;
  div_t        d_r;
  logic        vld_r;

  always_comb begin
    so_sh = {in_d.so.rem, in_d.so.num[46]};
    co_sh = {in_d.co.rem, in_d.co.num[46]};
    so_ge = so_sh >= {1'b0, in_d.den};
    co_ge = co_sh >= {1'b0, in_d.den};
    d_nxt = in_d;
    d_nxt.so.num = {in_d.so.num[45:0], 1'b0};
    d_nxt.co.num = {in_d.co.num[45:0], 1'b0};
    d_nxt.so.quo = {in_d.so.quo[45:0], so_ge};
    d_nxt.co.quo = {in_d.co.quo[45:0], co_ge};
    d_nxt.so.rem = so_ge ? 32'(so_sh - {1'b0, in_d.den}) : so_sh[31:0];
    d_nxt.co.rem = co_ge ? 32'(co_sh - {1'b0, in_d.den}) : co_sh[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_d   = d_r;
endmodule

[src/ctp_checker.sv]
// Port-level checks for coordinated_turn_predict, attached by bind.
// Depends on coordinated_turn_predict port names only.
module ctp_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [255:0] in_tdata,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [223:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result word changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output stall");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_in_stable: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata))
    else $error("input word changed while waiting");

endmodule

bind coordinated_turn_predict ctp_checker u_ctp_checker (.*);

[verif/tb.sv]
// Self-checking bench for coordinated_turn_predict: random and directed target states,
// with expected propagated states computed in a local bit-exact turn predictor.
// Depends on ctp_pkg (for CORDIC_STEPS) and the RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ctp_pkg::*;

  localparam longint PI60 = 64'sh3243F6A8885A308D;
  localparam longint PI44 = (PI60 + 64'sd32768) >>> 16;
  localparam longint HPI44 = (PI60 + 64'sd65536) >>> 17;
  localparam longint TPI44 = (PI60 + 64'sd16384) >>> 15;
  localparam longint GAIN30 = 64'sd652032874;
  localparam longint ONE30 = 64'sd1 << 30;
  localparam longint QLIM = 64'sh0FFFFFFFF;
  localparam int N_RANDOM = 1630;

  typedef struct {
    logic signed [31:0] px, py, pz, vx, vy, vz, w;
    logic [31:0] dt;
  } track_t;

  typedef logic [223:0] state_word_t;

  function automatic longint sat_q16(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clamp_q(longint v);
    if (v > QLIM) return QLIM;
    if (v < -QLIM) return -QLIM;
    return v;
  endfunction

  function automatic longint atan_step(int i);
    longint sum, term;
    int sh;
    sum = 0;
    if (i == 0) return ((PI60 >>> 2) + 64'sd32768) >>> 16;
    for (int k = 0; k < 64; k++) begin
      sh = 60 - i * (2 * k + 1);
      if (sh >= 0) begin
        term = (64'sd1 <<< sh) / longint'(2 * k + 1);
        sum = k[0] ? sum - term : sum + term;
      end
    end
    return (sum + 64'sd32768) >>> 16;
  endfunction

  function automatic void turn_sincos(longint theta, output longint s, output longint c);
    logic [63:0] mag;
    longint r, x, y, xs, ys;
    bit flip;
    flip = 0;
    mag = theta < 0 ? -theta : theta;
    r = longint'(mag % 64'(TPI44));
    if (theta < 0) r = -r;
    if (r > PI44) r -= TPI44;
    if (r < -PI44) r += TPI44;
    if (r > HPI44) begin
      r -= PI44;
      flip = 1;
    end else if (r < -HPI44) begin
      r += PI44;
      flip = 1;
    end
    x = GAIN30;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (r >= 0) begin
        x -= ys; y += xs; r -= atan_step(i);
      end else begin
        x += ys; y -= xs; r += atan_step(i);
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic state_word_t predict_turn(track_t t);
    longint px, py, pz, vx, vy, vz, w, dt, nx, ny, nz, nvx, nvy, s, c, so, co;
    px = t.px; py = t.py; pz = t.pz; vx = t.vx; vy = t.vy; vz = t.vz; w = t.w;
    dt = longint'({32'd0, t.dt});
    nz = sat_q16(pz + ((vz * dt) >>> 16));
    if (w == 0) begin
      nx = sat_q16(px + ((vx * dt) >>> 16));
      ny = sat_q16(py + ((vy * dt) >>> 16));
      nvx = vx;
      nvy = vy;
    end else begin
      turn_sincos(w * dt, s, c);
      so = clamp_q((s * 16384) / w);
      co = clamp_q(((ONE30 - c) * 16384) / w);
      nx = sat_q16(px + ((so * vx) >>> 16) - ((co * vy) >>> 16));
      ny = sat_q16(py + ((co * vx) >>> 16) + ((so * vy) >>> 16));
      nvx = sat_q16((c * vx - s * vy) >>> 30);
      nvy = sat_q16((s * vx + c * vy) >>> 30);
    end
    return {t.w, t.vz, nvy[31:0], nvx[31:0], nz[31:0], ny[31:0], nx[31:0]};
  endfunction

  int n_errors = 0;

  task automatic report_mismatch(string what);
    $display("mismatch: %s", what);
    n_errors++;
  endtask

  class turn_scoreboard;
    state_word_t pending[$];
    function void note_input(track_t t);
      pending.push_back(predict_turn(t));
    endfunction
    task check_result(state_word_t got);
      state_word_t exp_w;
      if (pending.size() == 0) begin
        report_mismatch("unexpected word");
        return;
      end
      exp_w = pending.pop_front();
      for (int f = 0; f < 7; f++)
        if (got[f*32 +: 32] !== exp_w[f*32 +: 32])
          report_mismatch($sformatf("field %0d got %h exp %h", f, got[f*32 +: 32],
                                    exp_w[f*32 +: 32]));
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [255:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [223:0] out_tdata;
  bit hold_off = 0;
  bit stim_done = 0;
  turn_scoreboard sb = new();

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  coordinated_turn_predict dut (.*);

  function automatic logic [31:0] rand_field();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(0, 1) ? 32'($urandom_range(0, 255)) : -32'($urandom_range(0, 255));
      default: return $urandom();
    endcase
  endfunction

  function automatic track_t rand_track();
    track_t t;
    t.px = rand_field(); t.py = rand_field(); t.pz = rand_field();
    t.vx = $urandom_range(0, 3) == 0 ? rand_field() : $signed(32'($urandom())) >>> 8;
    t.vy = $urandom_range(0, 3) == 0 ? rand_field() : $signed(32'($urandom())) >>> 8;
    t.vz = rand_field();
    case ($urandom_range(0, 5))
      0: t.w = 0;
      1: t.w = $urandom_range(0, 1) ? 32'sd1 : -32'sd1;
      2: t.w = rand_field();
      default: t.w = $signed(32'($urandom())) >>> $urandom_range(0, 8);
    endcase
    t.dt = $urandom_range(0, 4) == 0 ? rand_field() : 32'($urandom_range(0, 32'h4_0000));
    return t;
  endfunction

  task automatic send_track(track_t t);
    in_tdata <= {t.dt, t.w, t.vz, t.vy, t.vx, t.pz, t.py, t.px};
    in_tvalid <= 1;
    do @(posedge clk); while (!in_tready);
    sb.note_input(t);
  endtask

  task automatic idle_sender();
    in_tvalid <= 0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  initial begin
    track_t t;
    logic [31:0] ext[4];
    int burst;
    ext = '{32'h7FFFFFFF, 32'h80000000, 32'h0, 32'hFFFFFFFF};
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    for (int i = 0; i < 20; i++) begin
      t.px = ext[i % 4]; t.py = ext[(i + 1) % 4]; t.pz = ext[(i + 2) % 4];
      t.vx = ext[(i + 3) % 4]; t.vy = ext[i % 4]; t.vz = ext[(i / 4) % 4];
      t.w = i < 4 ? 32'sd0 : (i < 8 ? ext[i % 4] : (i < 12 ? 32'sd1 : -32'sd1));
      t.dt = ext[(i / 2) % 4];
      send_track(t);
    end
    for (int n = 0; n < N_RANDOM; n += burst) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst; k++) send_track(rand_track());
      if ($urandom_range(0, 1)) idle_sender();
    end
    in_tvalid <= 0;
    stim_done = 1;
  end

  initial begin
    repeat (400) @(posedge clk);
    hold_off = 1;
    repeat (600) @(posedge clk);
    hold_off = 0;
  end

  always @(posedge clk) begin
    if (out_tvalid && out_tready) sb.check_result(out_tdata);
    if (hold_off) begin
      out_tready <= 0;
    end else if (($time / 3000) % 3 == 0) begin
      out_tready <= 1;
    end else begin
      out_tready <= $urandom_range(0, 3) != 0;
    end
  end

  initial begin
    wait (stim_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule

[sim.f]
src/ctp_pkg.sv
src/ctp_mod_cell.sv
src/ctp_cordic_cell.sv
src/ctp_div_cell.sv
src/coordinated_turn_predict.sv
src/ctp_checker.sv
verif/tb.sv
